>>> src/lprt_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes, status codes and the prefix mask helper for the route table.
// No dependencies.
package lprt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [5:0] MAX_LEN = 6'd32;

	typedef logic [2:0] status_t;
	localparam status_t ST_ADDED = 3'd0;
	localparam status_t ST_DUP   = 3'd1;
	localparam status_t ST_FULL  = 3'd2;
	localparam status_t ST_HIT   = 3'd3;
	localparam status_t ST_MISS  = 3'd4;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef struct packed {
		logic [31:0] hop;
		logic [5:0]  len;
		logic [31:0] prefix;
	} route_t;

	localparam int ROUTE_W = $bits(route_t);

	// top len bits set; len is already saturated to 32
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len >= MAX_LEN) begin
			m = 32'hffff_ffff;
		end else begin
			m = ~(32'hffff_ffff >> len);
		end
		return m;
	endfunction

endpackage

>>> src/lprt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/lprt_match.sv
`timescale 1ns / 1ps
// Route entry compare: duplicate check for adds, masked prefix match for lookups.
// Depends on lprt_pkg.
module lprt_match (
	input  lprt_pkg::route_t ent,
	input  lprt_pkg::op_t    op,
	input  logic [31:0]      key,
	input  logic [5:0]       key_len,
	output logic             hit
);
	import lprt_pkg::*;

	always_comb begin
		case (op)
			OP_ADD:    hit = (ent.prefix == key) && (ent.len == key_len);
			OP_LOOKUP: hit = ((key & len_mask(ent.len)) == ent.prefix);
			default:   hit = 1'b0;
		endcase
	end

endmodule

>>> src/longest_prefix_route_table.sv
`timescale 1ns / 1ps
// Top level of the IPv4 longest-prefix-match route table.
// Depends on lprt_pkg, lprt_ram and lprt_match.
//
// Routes live in one synchronous RAM and fill slots in order, so a fill count
// marks the valid ones and reset clears the table at once. Every word, add or
// lookup, reads each stored route once, one per cycle, before its result is
// registered. The input takes the next word in the cycle after the result has
// moved into the output register, so a new word is not accepted until the
// previous one is finished; a stalled output holds the finished word and with
// it the input. Prefix lengths above 32 are treated as 32; a prefix with bits
// set below its mask is stored but never matches.
module longest_prefix_route_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // address[31:0], prefix_len[37:32], next_hop[69:38], zero
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // hop_out[31:0], match_len[37:32], zero
	output logic [2:0]  m_tuser    // status
);
	import lprt_pkg::*;

	typedef enum logic [2:0] {
		IDLE = 3'b001,
		SCAN = 3'b010,
		FIN  = 3'b100
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [31:0]      key_q;
	logic [5:0]       len_q;
	logic [31:0]      hop_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic             found_q;
	logic [5:0]       best_len_q;
	logic [31:0]      best_hop_q;

	logic             out_vld_q;
	status_t          out_st_q;
	logic [31:0]      out_hop_q;
	logic [5:0]       out_len_q;

	route_t           rd_ent;
	route_t           wr_ent;
	logic             wr_en;
	logic             ent_hit;
	logic             s_acc;
	logic             fin_go;
	logic [5:0]       in_len;
	logic             full;

	assign s_tready = (state_q == IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_len   = (s_tdata[37:32] > MAX_LEN) ? MAX_LEN : s_tdata[37:32];
	assign full     = (count_q == CNT_W'(TABLE_ENTRIES));
	assign fin_go   = (state_q == FIN) && (!out_vld_q || m_tready);
	assign wr_en    = fin_go && (op_q == OP_ADD) && !found_q && !full;

	assign wr_ent.hop    = hop_q;
	assign wr_ent.len    = len_q;
	assign wr_ent.prefix = key_q;

	lprt_ram #(
		.WIDTH(ROUTE_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_ent),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_ent)
	);

	lprt_match u_match (
		.ent     (rd_ent),
		.op      (op_q),
		.key     (key_q),
		.key_len (len_q),
		.hit     (ent_hit)
	);

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= op_t'(s_tuser);
			key_q <= s_tdata[31:0];
			len_q <= in_len;
			hop_q <= s_tdata[69:38];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			best_len_q <= '0;
			best_hop_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (s_acc) begin
						idx_q      <= '0;
						found_q    <= 1'b0;
						best_len_q <= '0;
						best_hop_q <= '0;
						state_q    <= SCAN;
					end
				end
				SCAN: begin
					if (idx_q < count_q) begin
						idx_q     <= idx_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						if (!rd_vld_s1) begin
							state_q <= FIN;
						end
					end
					if (rd_vld_s1 && ent_hit) begin
						found_q <= 1'b1;
						if (!found_q || rd_ent.len > best_len_q) begin
							best_len_q <= rd_ent.len;
							best_hop_q <= rd_ent.hop;
						end
					end
				end
				FIN: begin
					rd_vld_s1 <= 1'b0;
					if (fin_go) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: begin
					state_q   <= IDLE;
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_go) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (op_q == OP_ADD) begin
				out_st_q  <= found_q ? ST_DUP : (full ? ST_FULL : ST_ADDED);
				out_hop_q <= '0;
				out_len_q <= '0;
			end else begin
				out_st_q  <= found_q ? ST_HIT : ST_MISS;
				out_hop_q <= found_q ? best_hop_q : 32'd0;
				out_len_q <= found_q ? best_len_q : 6'd0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {2'b00, out_len_q, out_hop_q};

endmodule

>>> tb/sv/longest_prefix_route_table_tb.sv
`timescale 1ns / 1ps
// Testbench for longest_prefix_route_table: directed adds and lookups, random traffic
// under several idle/stall mixes, and a long output hold-off. Depends on lprt_pkg and the RTL.
module longest_prefix_route_table_tb;
	import lprt_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		status_t     status;
		logic [31:0] hop;
		logic [5:0]  len;
	} route_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;

	// routes fill slots in order, so slots below route_count are the valid ones
	logic [31:0] route_prefix [TABLE_ENTRIES];
	logic [5:0]  route_len    [TABLE_ENTRIES];
	logic [31:0] route_hop    [TABLE_ENTRIES];
	int          route_count = 0;

	route_result_t pending_results[$];
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_left     = 0;
	int errors        = 0;
	int cycles        = 0;
	int words_sent    = 0;
	int status_seen[5] = '{default: 0};

	longest_prefix_route_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [5:0] clamp_len(input logic [5:0] len);
		return (len > 6'd32) ? 6'd32 : len;
	endfunction

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [63:0] wide;
		wide = 64'hffff_ffff_0000_0000 >> clamp_len(len);
		return wide[31:0];
	endfunction

	// updates the route store and returns the result the word should produce
	function automatic route_result_t apply_route_word(input op_t op, input logic [31:0] addr,
			input logic [5:0] len_in, input logic [31:0] hop);
		route_result_t r;
		logic [5:0]    len;
		logic          found;
		len      = clamp_len(len_in);
		r.status = ST_MISS;
		r.hop    = '0;
		r.len    = '0;
		found    = 1'b0;
		if (op == OP_ADD) begin
			r.status = ST_ADDED;
			for (int i = 0; i < route_count; i++) begin
				if (route_prefix[i] == addr && route_len[i] == len)
					found = 1'b1;
			end
			if (found) begin
				r.status = ST_DUP;
			end else if (route_count >= TABLE_ENTRIES) begin
				r.status = ST_FULL;
			end else begin
				route_prefix[route_count] = addr;
				route_len[route_count]    = len;
				route_hop[route_count]    = hop;
				route_count++;
			end
		end else begin
			for (int i = 0; i < route_count; i++) begin
				if ((addr & prefix_mask(route_len[i])) == route_prefix[i] &&
						(!found || route_len[i] > r.len)) begin
					found = 1'b1;
					r.len = route_len[i];
					r.hop = route_hop[i];
				end
			end
			if (found)
				r.status = ST_HIT;
		end
		return r;
	endfunction

	task automatic send_word(input op_t op, input logic [31:0] addr, input logic [5:0] len,
			input logic [31:0] hop);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, hop, len, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_route_word(op, addr, len, hop));
		words_sent++;
	endtask

	task automatic check_directed_routes();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		send_word(OP_LOOKUP, 32'h0a01_0203, 6'd0,  32'h0);           // empty table
		send_word(OP_ADD,    32'h0a00_0000, 6'd8,  32'h1111_1111);
		send_word(OP_ADD,    32'h0a01_0000, 6'd16, 32'h2222_2222);
		send_word(OP_ADD,    32'h0a01_0200, 6'd24, 32'h3333_3333);
		send_word(OP_ADD,    32'hffff_ffff, 6'd32, 32'hffff_ffff);
		send_word(OP_ADD,    32'h0a01_0203, 6'd63, 32'h0);           // saturates to 32
		send_word(OP_ADD,    32'h0a01_0203, 6'd32, 32'h4444_4444);   // duplicate
		send_word(OP_ADD,    32'h0a01_0203, 6'd40, 32'h5555_5555);   // duplicate after clamp
		send_word(OP_ADD,    32'hc0a8_0001, 6'd24, 32'h6666_6666);   // host bits set
		send_word(OP_LOOKUP, 32'h0a01_0203, 6'h3f, 32'hffff_ffff);
		send_word(OP_LOOKUP, 32'h0a01_02ff, 6'd0,  32'h0);
		send_word(OP_LOOKUP, 32'h0a01_ffff, 6'd17, 32'h0);
		send_word(OP_LOOKUP, 32'h0aff_ffff, 6'd0,  32'h0);
		send_word(OP_LOOKUP, 32'hc0a8_0001, 6'h3f, 32'hffff_ffff);   // never matches
		send_word(OP_LOOKUP, 32'hffff_ffff, 6'd0,  32'h0);
		send_word(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0);
		send_word(OP_ADD,    32'h0000_0000, 6'd0,  32'h7777_7777);   // default route
		send_word(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0);
		send_word(OP_LOOKUP, 32'hc0a8_0001, 6'd0,  32'h0);
		send_word(OP_ADD,    32'h1234_5678, 6'd0,  32'h8888_8888);   // length 0, nonzero prefix
		send_word(OP_LOOKUP, 32'h1234_5678, 6'd0,  32'h0);
	endtask

	task automatic run_random_traffic(input int words, input int idle_pct, input int stall_pct);
		op_t         op;
		logic [31:0] addr;
		logic [31:0] hop;
		logic [31:0] mask;
		logic [5:0]  len;
		int          pick;
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		for (int n = 0; n < words; n++) begin
			hop  = $urandom();
			addr = $urandom();
			if ($urandom_range(99) < 25) begin
				op = OP_ADD;
				if (route_count > 0 && $urandom_range(99) < 20) begin
					pick = $urandom_range(route_count - 1);
					addr = route_prefix[pick];
					len  = route_len[pick];
					if (len == 6'd32 && $urandom_range(1) == 1)
						len = 6'($urandom_range(63, 33));
				end else begin
					if ($urandom_range(99) < 10)
						len = 6'($urandom_range(63, 33));
					else
						len = 6'($urandom_range(32));
					if ($urandom_range(99) < 85)
						addr &= prefix_mask(len);
				end
			end else begin
				op  = OP_LOOKUP;
				len = 6'($urandom());
				if (route_count > 0 && $urandom_range(99) < 75) begin
					pick = $urandom_range(route_count - 1);
					mask = prefix_mask(route_len[pick]);
					addr = (route_prefix[pick] & mask) | (addr & ~mask);
				end
			end
			send_word(op, addr, len, hop);
		end
	endtask

	// output held off while words keep coming, so the input must stall
	task automatic fill_under_backpressure();
		hold_left = 400;
		run_random_traffic(30, 0, 0);
	endtask

	always @(posedge clk) begin : result_check
		route_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tuser < 3'd5)
				status_seen[m_tuser]++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending: status %0d", m_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
				if (m_tdata[31:0] !== want.hop) begin
					$error("hop_out: expected %08h, got %08h", want.hop, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[37:32] !== want.len) begin
					$error("match_len: expected %0d, got %0d", want.len, m_tdata[37:32]);
					errors++;
				end
			end
		end
	end

	// receiver side: long hold-off counted here, otherwise random stalls
	always @(posedge clk) begin : sink_ready
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_directed_routes();
		run_random_traffic(500, 0, 0);
		run_random_traffic(500, 86, 0);
		run_random_traffic(500, 0, 86);
		run_random_traffic(500, 21, 21);
		fill_under_backpressure();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d words over idle/stall mixes and a long hold-off, %0d routes stored",
			words_sent, route_count);
		$display("results: %0d added, %0d duplicate, %0d full, %0d hit, %0d miss",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/lprt_pkg.sv
src/lprt_ram.sv
src/lprt_match.sv
src/longest_prefix_route_table.sv
tb/sv/longest_prefix_route_table_tb.sv
